>>> rtl/quartet_topology_rank_macros.svh
// Assertion macros used by the checker of the quartet ranking block.
`ifndef QUARTET_TOPOLOGY_RANK_MACROS_SVH
`define QUARTET_TOPOLOGY_RANK_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define QTR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("quartet rank check failed");

// An implication that must hold at every rising clock edge outside reset.
`define QTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quartet rank implication failed");

`endif

>>> rtl/qtr_pkg.sv
// Shared widths, types and helpers of the quartet ranking pipeline.
package qtr_pkg;

  localparam int unsigned LABEL_W = 11;
  localparam int unsigned RANK_W  = 37;
  localparam int unsigned PAIR_W  = 2 * LABEL_W;
  localparam int unsigned QUAD_W  = 2 * PAIR_W;
  localparam int unsigned CUBE_W  = 3 * LABEL_W;
  localparam int unsigned T3_W    = CUBE_W - 1;
  localparam int unsigned T2_W    = PAIR_W + 1;
  localparam int unsigned T1_W    = LABEL_W + 2;
  localparam int unsigned LO_W    = T2_W + 1;

  typedef logic [LABEL_W-1:0] label_t;

  // Topology of the canonical quartet a|b c|d.
  typedef enum logic [1:0] {
    TOPO_41_32 = 2'd0,
    TOPO_42_31 = 2'd1,
    TOPO_43_21 = 2'd2
  } topo_e;

  // Canonical labels and topology, carried alongside the arithmetic.
  typedef struct packed {
    topo_e  topo;
    label_t a;
    label_t b;
    label_t c;
    label_t d;
  } canon_t;

  // Binomial arguments (label minus one) in order of weight, four down to one.
  typedef struct packed {
    canon_t canon;
    label_t n4;
    label_t n3;
    label_t n2;
    label_t n1;
  } digits_t;

  // Each term already multiplied by three, reduced to the width it needs; t4 is cut to the rank width.
  typedef struct packed {
    canon_t              canon;
    logic [RANK_W-1:0]   t4;
    logic [T3_W-1:0]     t3;
    logic [T2_W-1:0]     t2;
    logic [T1_W-1:0]     t1;
  } terms_t;

  // Label minus one; a zero label counts as zero so that every term vanishes.
  function automatic label_t label_below(input label_t x);
    label_below = (x == '0) ? '0 : x - label_t'(1);
  endfunction

endpackage

>>> rtl/qtr_canon.sv
// Canonical ordering of the quartet and choice of topology, two register stages.
module qtr_canon
  import qtr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  label_t  left_one_i,
  input  label_t  left_two_i,
  input  label_t  right_one_i,
  input  label_t  right_two_i,
  output logic    valid_o,
  output digits_t digits_o
);

  label_t  l_hi, l_lo, r_hi, r_lo;
  logic    lead_swap;
  label_t  a_d, b_d, c_d, d_d;
  logic    s1_valid_q;
  label_t  a_q, b_q, c_q, d_q;
  topo_e   topo_d;
  label_t  x4, x3, x2, x1;
  digits_t digits_d;
  logic    s2_valid_q;
  digits_t digits_q;

  // Each pair larger first, then the pair with the larger leader goes left.
  always_comb begin
    l_hi      = (left_one_i < left_two_i) ? left_two_i : left_one_i;
    l_lo      = (left_one_i < left_two_i) ? left_one_i : left_two_i;
    r_hi      = (right_one_i < right_two_i) ? right_two_i : right_one_i;
    r_lo      = (right_one_i < right_two_i) ? right_one_i : right_two_i;
    lead_swap = l_hi < r_hi;
    a_d       = lead_swap ? r_hi : l_hi;
    b_d       = lead_swap ? r_lo : l_lo;
    c_d       = lead_swap ? l_hi : r_hi;
    d_d       = lead_swap ? l_lo : r_lo;
  end

  // The topology decides which label feeds which binomial.
  always_comb begin
    if (b_q > c_q) begin
      topo_d = TOPO_43_21;
      x4 = a_q; x3 = b_q; x2 = c_q; x1 = d_q;
    end else if (b_q > d_q) begin
      topo_d = TOPO_42_31;
      x4 = a_q; x3 = c_q; x2 = b_q; x1 = d_q;
    end else begin
      topo_d = TOPO_41_32;
      x4 = a_q; x3 = c_q; x2 = d_q; x1 = b_q;
    end
    digits_d.canon.topo = topo_d;
    digits_d.canon.a    = a_q;
    digits_d.canon.b    = b_q;
    digits_d.canon.c    = c_q;
    digits_d.canon.d    = d_q;
    digits_d.n4         = label_below(x4);
    digits_d.n3         = label_below(x3);
    digits_d.n2         = label_below(x2);
    digits_d.n1         = label_below(x1);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Data registers of both stages.
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    digits_q <= digits_d;
  end

  assign valid_o  = s2_valid_q;
  assign digits_o = digits_q;

endmodule

>>> rtl/qtr_terms.sv
// Falling-factorial products giving three times each binomial, two register stages.
module qtr_terms
  import qtr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  digits_t digits_i,
  output logic    valid_o,
  output terms_t  terms_o
);

  // Three times C(n,4) is n(n-1)(n-2)(n-3)/8, three times C(n,3) is
  // n(n-1)(n-2)/2, so no division by three is ever needed.
  logic [PAIR_W-1:0]  p4_q, q4_q, p3_q, p2_q;
  label_t             m3_q, n1_q;
  canon_t             canon_q;
  logic               s3_valid_q;
  logic [QUAD_W-1:0]  prod4;
  logic [CUBE_W-1:0]  prod3;
  logic [PAIR_W-2:0]  half2;
  terms_t             terms_d;
  terms_t             terms_q;
  logic               s4_valid_q;

  // Second stage: the wide products and the cheap small terms.
  always_comb begin
    prod4 = QUAD_W'(p4_q) * QUAD_W'(q4_q);
    prod3 = CUBE_W'(p3_q) * CUBE_W'(m3_q);
    half2 = p2_q[PAIR_W-1:1];
    terms_d.canon = canon_q;
    terms_d.t4    = prod4[RANK_W+2:3];
    terms_d.t3    = prod3[CUBE_W-1:1];
    terms_d.t2    = T2_W'(half2) + T2_W'({half2, 1'b0});
    terms_d.t1    = T1_W'(n1_q) + T1_W'({n1_q, 1'b0});
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  // First stage forms the pair products; a wrapped factor always meets a zero one.
  always_ff @(posedge clk_i) begin
    p4_q    <= PAIR_W'(digits_i.n4) * PAIR_W'(digits_i.n4 - label_t'(1));
    q4_q    <= PAIR_W'(digits_i.n4 - label_t'(2)) * PAIR_W'(digits_i.n4 - label_t'(3));
    p3_q    <= PAIR_W'(digits_i.n3) * PAIR_W'(digits_i.n3 - label_t'(1));
    m3_q    <= digits_i.n3 - label_t'(2);
    p2_q    <= PAIR_W'(digits_i.n2) * PAIR_W'(digits_i.n2 - label_t'(1));
    n1_q    <= digits_i.n1;
    canon_q <= digits_i.canon;
    terms_q <= terms_d;
  end

  assign valid_o = s4_valid_q;
  assign terms_o = terms_q;

endmodule

>>> rtl/qtr_sum.sv
// Adder tree that folds the four terms and the topology into the rank, two stages.
module qtr_sum
  import qtr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  terms_t            terms_i,
  output logic              valid_o,
  output logic [RANK_W-1:0] rank_o,
  output canon_t            canon_o
);

  logic [RANK_W-1:0] hi_q;
  logic [LO_W-1:0]   lo_q;
  canon_t            canon5_q;
  logic              s5_valid_q;
  logic [RANK_W-1:0] rank_q;
  canon_t            canon6_q;
  logic              s6_valid_q;

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= valid_i;
      s6_valid_q <= s5_valid_q;
    end
  end

  // Large terms and small terms are summed apart, then joined modulo the rank width.
  always_ff @(posedge clk_i) begin
    hi_q     <= terms_i.t4 + RANK_W'(terms_i.t3);
    lo_q     <= LO_W'(terms_i.t2) + LO_W'(terms_i.t1) + LO_W'(terms_i.canon.topo);
    canon5_q <= terms_i.canon;
    rank_q   <= hi_q + RANK_W'(lo_q);
    canon6_q <= canon5_q;
  end

  assign valid_o = s6_valid_q;
  assign rank_o  = rank_q;
  assign canon_o = canon6_q;

endmodule

>>> rtl/quartet_topology_rank.sv
// Quartet ranking block: six register stages, one word accepted in every cycle.
// Throughput: one word per cycle; busy_o never rises, as the receiver cannot stall.
// Reset: rst_ni clears every valid bit at once; words in flight are dropped.
module quartet_topology_rank
  import qtr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  label_t            left_one_i,
  input  label_t            left_two_i,
  input  label_t            right_one_i,
  input  label_t            right_two_i,
  output logic              done_o,
  output logic [RANK_W-1:0] quartet_rank_o,
  output logic [1:0]        topology_case_o,
  output label_t            canon_left_big_o,
  output label_t            canon_left_small_o,
  output label_t            canon_right_big_o,
  output label_t            canon_right_small_o
);

  logic    accept;
  logic    digits_valid;
  digits_t digits;
  logic    terms_valid;
  terms_t  terms;
  canon_t  canon;

  // The pipeline never holds, so a word is taken whenever start is high.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  qtr_canon u_canon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .left_one_i  (left_one_i),
    .left_two_i  (left_two_i),
    .right_one_i (right_one_i),
    .right_two_i (right_two_i),
    .valid_o     (digits_valid),
    .digits_o    (digits)
  );

  qtr_terms u_terms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (digits_valid),
    .digits_i (digits),
    .valid_o  (terms_valid),
    .terms_o  (terms)
  );

  qtr_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (terms_valid),
    .terms_i (terms),
    .valid_o (done_o),
    .rank_o  (quartet_rank_o),
    .canon_o (canon)
  );

  // Canonical labels leave with the rank.
  assign topology_case_o     = canon.topo;
  assign canon_left_big_o    = canon.a;
  assign canon_left_small_o  = canon.b;
  assign canon_right_big_o   = canon.c;
  assign canon_right_small_o = canon.d;

endmodule

>>> rtl/qtr_checker.sv
// Port-level checks of the quartet ranking block and their binding to the top level.
`include "quartet_topology_rank_macros.svh"

module qtr_checker
  import qtr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [1:0]        topology_case_o,
  input label_t            canon_left_big_o,
  input label_t            canon_left_small_o,
  input label_t            canon_right_big_o,
  input label_t            canon_right_small_o
);

  // Every accepted word comes out as a result.
  `QTR_ASSERT_IMP(a_accept_done, clk_i, rst_ni, start_i && !busy_o, ##6 done_o)

  // No result appears without a matching accepted word.
  `QTR_ASSERT_IMP(a_done_accept, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 6))

  // Both pairs are ordered larger first and the left leader is the largest.
  `QTR_ASSERT_IMP(a_canon_order, clk_i, rst_ni, done_o,
    canon_left_big_o >= canon_left_small_o && canon_right_big_o >= canon_right_small_o
    && canon_left_big_o >= canon_right_big_o)

  // The split with both large labels on the left is reported only when it holds.
  `QTR_ASSERT_IMP(a_topo_top, clk_i, rst_ni, done_o && topology_case_o == TOPO_43_21,
    canon_left_small_o > canon_right_big_o)

endmodule

bind quartet_topology_rank qtr_checker u_qtr_checker (.*);

>>> test/tb_top.sv
// Testbench of the quartet ranking block: directed and random quartets checked by a predictor.
module tb_top;
  import qtr_pkg::*;

  localparam int unsigned MAX_LABEL = 1024;

  // One expected result word: rank, topology and the canonical labels.
  typedef struct {
    logic [RANK_W-1:0] rank;
    topo_e             topo;
    label_t            a;
    label_t            b;
    label_t            c;
    label_t            d;
  } quartet_rank_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  label_t            left_one_i;
  label_t            left_two_i;
  label_t            right_one_i;
  label_t            right_two_i;
  logic              done_o;
  logic [RANK_W-1:0] quartet_rank_o;
  logic [1:0]        topology_case_o;
  label_t            canon_left_big_o;
  label_t            canon_left_small_o;
  label_t            canon_right_big_o;
  label_t            canon_right_small_o;

  quartet_rank_t pending_ranks[$];
  int unsigned   mismatches = 0;
  bit            idle_on = 1'b1;

  quartet_topology_rank dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .left_one_i          (left_one_i),
    .left_two_i          (left_two_i),
    .right_one_i         (right_one_i),
    .right_two_i         (right_two_i),
    .done_o              (done_o),
    .quartet_rank_o      (quartet_rank_o),
    .topology_case_o     (topology_case_o),
    .canon_left_big_o    (canon_left_big_o),
    .canon_left_small_o  (canon_left_small_o),
    .canon_right_big_o   (canon_right_big_o),
    .canon_right_small_o (canon_right_small_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Binomial C(x-1, k) for k in 1..4; zero whenever x-1 falls below k.
  function automatic logic [63:0] binom_below(input label_t x, input int unsigned k);
    logic [63:0] n;
    n = 64'(x) - 64'd1;
    if (64'(x) <= 64'(k)) return 64'd0;
    case (k)
      1: return n;
      2: return n * (n - 1) / 2;
      3: return n * (n - 1) * (n - 2) / 6;
      default: return n * (n - 1) * (n - 2) * (n - 3) / 24;
    endcase
  endfunction

  // Canonical form, topology and rank of one quartet split.
  function automatic quartet_rank_t rank_quartet(input label_t l1, input label_t l2,
                                                 input label_t r1, input label_t r2);
    quartet_rank_t q;
    label_t        t;
    logic [63:0]   sum;
    logic [63:0]   full;
    q.a = l1;
    q.b = l2;
    q.c = r1;
    q.d = r2;
    // Larger label first in each pair; equal labels stay where they are.
    if (q.a < q.b) begin
      t = q.a; q.a = q.b; q.b = t;
    end
    if (q.c < q.d) begin
      t = q.c; q.c = q.d; q.d = t;
    end
    // The pair with the larger leader goes to the left.
    if (q.a < q.c) begin
      t = q.a; q.a = q.c; q.c = t;
      t = q.b; q.b = q.d; q.d = t;
    end
    if (q.b > q.c) begin
      q.topo = TOPO_43_21;
      sum = binom_below(q.a, 4) + binom_below(q.b, 3) + binom_below(q.c, 2) +
            binom_below(q.d, 1);
    end else if (q.b > q.d) begin
      q.topo = TOPO_42_31;
      sum = binom_below(q.a, 4) + binom_below(q.c, 3) + binom_below(q.b, 2) +
            binom_below(q.d, 1);
    end else begin
      q.topo = TOPO_41_32;
      sum = binom_below(q.a, 4) + binom_below(q.c, 3) + binom_below(q.d, 2) +
            binom_below(q.b, 1);
    end
    // The rank wraps at its port width.
    full = sum * 64'd3 + {62'd0, q.topo};
    q.rank = full[RANK_W-1:0];
    return q;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Each result word is compared with the oldest one still expected.
  always @(negedge clk_i) begin
    quartet_rank_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (pending_ranks.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, got rank %0d", $time, quartet_rank_o);
      end else begin
        want = pending_ranks.pop_front();
        check_field("quartet_rank", want.rank, quartet_rank_o);
        check_field("topology_case", want.topo, topology_case_o);
        check_field("canon_left_big", want.a, canon_left_big_o);
        check_field("canon_left_small", want.b, canon_left_small_o);
        check_field("canon_right_big", want.c, canon_right_big_o);
        check_field("canon_right_small", want.d, canon_right_small_o);
      end
    end
  end

  // Offers one word, with random idle cycles first unless idle_on is clear, and records its expected result.
  task automatic send_quartet(input label_t l1, input label_t l2,
                              input label_t r1, input label_t r2);
    bit taken;
    while (idle_on && $urandom_range(99) < 36) begin
      start_i     <= 1'b0;
      left_one_i  <= label_t'($urandom);
      left_two_i  <= label_t'($urandom);
      right_one_i <= label_t'($urandom);
      right_two_i <= label_t'($urandom);
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    left_one_i  <= l1;
    left_two_i  <= l2;
    right_one_i <= r1;
    right_two_i <= r2;
    do begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    pending_ranks.push_back(rank_quartet(l1, l2, r1, r2));
  endtask

  // A random word: mostly distinct labels in the normal range, with noise around it.
  task automatic send_random_quartet();
    label_t      v[4];
    int unsigned mode;
    bit          dup;
    mode = $urandom_range(99);
    if (mode < 70) begin
      for (int i = 0; i < 4; i++) begin
        do begin
          v[i] = label_t'($urandom_range(MAX_LABEL, 1));
          dup = 1'b0;
          for (int j = 0; j < i; j++) if (v[j] == v[i]) dup = 1'b1;
        end while (dup);
      end
    end else if (mode < 85) begin
      // Any 11-bit value, labels above the normal range and zero among them.
      foreach (v[i]) v[i] = label_t'($urandom);
    end else if (mode < 95) begin
      // Repeated labels.
      v[0] = label_t'($urandom_range(MAX_LABEL, 1));
      for (int i = 1; i < 4; i++)
        v[i] = $urandom_range(1) ? v[$urandom_range(i - 1)]
                                 : label_t'($urandom_range(MAX_LABEL, 1));
    end else begin
      // Labels near the edges of the field and of the normal range.
      foreach (v[i]) begin
        case ($urandom_range(3))
          0: v[i] = label_t'($urandom_range(4, 1));
          1: v[i] = label_t'($urandom_range(MAX_LABEL, MAX_LABEL - 3));
          2: v[i] = label_t'($urandom_range(2047, 2044));
          default: v[i] = '0;
        endcase
      end
    end
    send_quartet(v[0], v[1], v[2], v[3]);
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_ranks.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_label_extremes();
    send_quartet(11'd1, 11'd2, 11'd3, 11'd4);
    send_quartet(11'd4, 11'd3, 11'd2, 11'd1);
    send_quartet(11'd1024, 11'd1023, 11'd1022, 11'd1021);
    send_quartet(11'd1, 11'd1024, 11'd2, 11'd1023);
    send_quartet(11'd1021, 11'd1, 11'd1024, 11'd3);
  endtask

  // Each topology reached from pairs given in different orders.
  task automatic test_topologies();
    send_quartet(11'd8, 11'd7, 11'd2, 11'd1);
    send_quartet(11'd1, 11'd2, 11'd7, 11'd8);
    send_quartet(11'd8, 11'd5, 11'd6, 11'd1);
    send_quartet(11'd1, 11'd6, 11'd5, 11'd8);
    send_quartet(11'd8, 11'd1, 11'd6, 11'd5);
    send_quartet(11'd5, 11'd6, 11'd1, 11'd8);
  endtask

  // Zero labels, labels above the normal range, a wrapping rank and repeated labels.
  task automatic test_odd_labels();
    send_quartet(11'd0, 11'd5, 11'd9, 11'd3);
    send_quartet(11'd0, 11'd0, 11'd0, 11'd0);
    send_quartet(11'd2047, 11'd1500, 11'd1025, 11'd1100);
    send_quartet(11'd2047, 11'd2046, 11'd2045, 11'd2044);
    send_quartet(11'd1365, 11'd682, 11'd2047, 11'd0);
    send_quartet(11'd5, 11'd5, 11'd5, 11'd5);
    send_quartet(11'd7, 11'd3, 11'd7, 11'd2);
    send_quartet(11'd4, 11'd9, 11'd9, 11'd4);
    send_quartet(11'd9, 11'd2, 11'd9, 11'd5);
  endtask

  // A few words, then the sender holds off until every result has come back.
  task automatic test_drain_pause();
    repeat (10) send_random_quartet();
    wait_for_results();
  endtask

  // Back-to-back words with no idle cycles at all.
  task automatic test_random_burst();
    idle_on = 1'b0;
    repeat (350) send_random_quartet();
    idle_on = 1'b1;
  endtask

  task automatic test_random_mixed();
    repeat (720) send_random_quartet();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    left_one_i  <= '0;
    left_two_i  <= '0;
    right_one_i <= '0;
    right_two_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_label_extremes();
    test_topologies();
    test_odd_labels();
    test_drain_pause();
    test_random_burst();
    test_random_mixed();

    // Let the pipeline drain, then wait on for any stray word.
    wait_for_results();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && pending_ranks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> quartet_topology_rank.f
+incdir+rtl
rtl/qtr_pkg.sv
rtl/qtr_canon.sv
rtl/qtr_terms.sv
rtl/qtr_sum.sv
rtl/quartet_topology_rank.sv
rtl/qtr_checker.sv
test/tb_top.sv
